@@ src/stp_pkg.sv @@
package stp_pkg;

    // Quotient bits kept by the dividers; larger results saturate anyway
    localparam int QW      = 25;
    localparam int NUM_W   = 64;
    localparam int DEN_W   = 49;
    localparam int DIV_LAT = QW + 2;

    typedef enum logic [2:0] {
        REG_TURN_RADIUS     = 3'd0,
        REG_TURN_ANGLE      = 3'd1,
        REG_RAMP_LENGTH     = 3'd2,
        REG_LEAD_IN_LENGTH  = 3'd3,
        REG_LEAD_OUT_LENGTH = 3'd4,
        REG_CELL_METERS     = 3'd5
    } reg_idx_t;

    typedef enum logic [2:0] {
        SEG_LEAD_IN,
        SEG_ARC,
        SEG_RAMP_IN,
        SEG_CONST,
        SEG_RAMP_OUT,
        SEG_DONE
    } seg_t;

    // Per-request control that travels with the data
    typedef struct packed {
        logic               vld;
        logic               bad;
        logic               neg;
        logic               fin;
        logic               th_neg;
        logic               om_neg;
        logic signed [15:0] spd;
    } side_t;

endpackage

@@ src/stp_if.sv @@
interface stp_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] travelled;
    logic signed [15:0] forward_speed;

    modport source (output valid, travelled, forward_speed, input ready);
    modport sink (input valid, travelled, forward_speed, output ready);
endinterface

interface stp_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] heading;
    logic signed [23:0] angular_rate;
    logic signed [15:0] speed_out;
    logic               valid_res;

    modport source (output valid, heading, angular_rate, speed_out, valid_res, input ready);
    modport sink (input valid, heading, angular_rate, speed_out, valid_res, output ready);
endinterface

@@ src/smooth_turn_heading_profile.sv @@
// Smooth-turn heading profile: for each request (distance travelled, forward
// speed) the block returns heading, angular rate, the speed and a valid flag
// from a lead-in / ramp-in / arc / ramp-out / lead-out profile set by six
// write-only registers. It takes one request per clock while the output is not
// stalled and returns each result through six stages of clamp, segment select,
// multiply and sign handling, 27 stages of the two pipelined restoring dividers
// (a rounding stage, an overflow stage, then one quotient bit per stage), and
// the output register. A stall at the output holds the whole pipeline.
// Registers may only be written while no request is in flight.
module smooth_turn_heading_profile
    import stp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [2:0]       cfg_index,
    input  logic [15:0]      cfg_data,
    stp_in_if.sink           sample,
    stp_out_if.source        result
);

    logic [15:0]        radius_reg;
    logic signed [15:0] angle_reg;
    logic [15:0]        ramp_len_reg;
    logic [15:0]        lead_in_reg;
    logic [15:0]        lead_out_reg;
    logic [15:0]        cell_reg;

    logic advance;

    // Write configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg   <= 16'd512;
            angle_reg    <= 16'sd6434;
            ramp_len_reg <= 16'd0;
            lead_in_reg  <= 16'd0;
            lead_out_reg <= 16'd0;
            cell_reg     <= 16'd11796;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_TURN_RADIUS:     radius_reg   <= cfg_data;
                REG_TURN_ANGLE:      angle_reg    <= $signed(cfg_data);
                REG_RAMP_LENGTH:     ramp_len_reg <= cfg_data;
                REG_LEAD_IN_LENGTH:  lead_in_reg  <= cfg_data;
                REG_LEAD_OUT_LENGTH: lead_out_reg <= cfg_data;
                REG_CELL_METERS:     cell_reg     <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Distances in Q.12 cells
    logic [27:0] pre;
    logic [27:0] ramp;
    logic [27:0] post;
    logic [28:0] rin;
    logic [15:0] angm;

    assign pre  = {lead_in_reg, 12'b0};
    assign ramp = {ramp_len_reg, 12'b0};
    assign post = {lead_out_reg, 12'b0};
    assign rin  = 29'(pre) + 29'(ramp);
    assign angm = angle_reg[15] ? (16'(~angle_reg) + 16'd1) : angle_reg;

    // ---------------- stage 1: products of the settings, clip below ----------
    side_t       s1_side_reg;
    logic [26:0] s1_d_reg;
    logic [31:0] s1_arc_reg;
    logic [31:0] s1_rcell_reg;
    logic [31:0] s1_rlr_reg;
    logic [29:0] s1_base_reg;
    side_t       s1_side_next;

    always_comb
    begin
        s1_side_next        = '0;
        s1_side_next.vld    = sample.valid;
        s1_side_next.bad    = (radius_reg == 16'd0) || (cell_reg == 16'd0)
                              || (angle_reg == 16'sd0);
        s1_side_next.neg    = angle_reg[15];
        s1_side_next.spd    = sample.forward_speed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_side_reg <= '0;
        else if (advance)
            s1_side_reg <= s1_side_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_d_reg     <= sample.travelled[15] ? 27'd0 : {sample.travelled[14:0], 12'b0};
            s1_arc_reg   <= 32'(angm) * 32'(radius_reg);
            s1_rcell_reg <= 32'(radius_reg) * 32'(cell_reg);
            s1_rlr_reg   <= 32'(ramp_len_reg) * 32'(radius_reg);
            s1_base_reg  <= 30'(rin) + 30'(post);
        end
    end

    // ---------------- stage 2: clamp to total length, boundaries -------------
    side_t       s2_side_reg;
    logic [26:0] s2_d_reg;
    logic [32:0] s2_cend_reg;
    logic [33:0] s2_rout_reg;
    logic [31:0] s2_rcell_reg;
    logic [31:0] s2_rlr_reg;
    logic [33:0] total;

    assign total = 34'(s1_base_reg) + 34'(s1_arc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_side_reg <= '0;
        else if (advance)
            s2_side_reg <= s1_side_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_d_reg     <= (34'(s1_d_reg) > total) ? 27'(total) : s1_d_reg;
            s2_cend_reg  <= 33'(pre) + 33'(s1_arc_reg);
            s2_rout_reg  <= 34'(rin) + 34'(s1_arc_reg);
            s2_rcell_reg <= s1_rcell_reg;
            s2_rlr_reg   <= s1_rlr_reg;
        end
    end

    // ---------------- stage 3: segment and offsets ---------------------------
    side_t              s3_side_reg;
    seg_t               s3_seg_reg;
    logic [26:0]        s3_s_reg;
    logic signed [29:0] s3_x_reg;
    logic [27:0]        s3_m_reg;
    logic [31:0]        s3_rcell_reg;
    logic [31:0]        s3_rlr_reg;
    seg_t               seg;
    logic [33:0]        dx;
    logic [26:0]        s_next;
    logic [27:0]        m_next;
    logic [30:0]        x_full;

    assign dx     = 34'(s2_d_reg);
    assign x_full = 31'({s2_d_reg, 1'b0}) - 31'({pre, 1'b0}) - 31'(ramp);

    // Pick the part of the profile in order
    always_comb
    begin
        priority if (dx <= 34'(pre))
            seg = SEG_LEAD_IN;
        else if (ramp_len_reg == 16'd0)
            seg = (dx <= 34'(s2_cend_reg)) ? SEG_ARC : SEG_DONE;
        else if (dx <= 34'(rin))
            seg = SEG_RAMP_IN;
        else if (dx <= 34'(s2_cend_reg))
            seg = SEG_CONST;
        else if (dx <= s2_rout_reg)
            seg = SEG_RAMP_OUT;
        else
            seg = SEG_DONE;
    end

    always_comb
    begin
        s_next = '0;
        m_next = '0;
        unique case (seg)
            SEG_ARC:      s_next = 27'(dx - 34'(pre));
            SEG_RAMP_IN:
            begin
                s_next = 27'(dx - 34'(pre));
                m_next = 28'(dx - 34'(pre));
            end
            SEG_CONST:    s_next = 27'(dx - 34'(rin));
            SEG_RAMP_OUT:
            begin
                s_next = 27'(dx - 34'(s2_cend_reg));
                m_next = 28'(s2_rout_reg - dx);
            end
            default:      ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_side_reg <= '0;
        else if (advance)
            s3_side_reg <= s2_side_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_seg_reg   <= seg;
            s3_s_reg     <= s_next;
            s3_x_reg     <= $signed(30'(x_full));
            s3_m_reg     <= m_next;
            s3_rcell_reg <= s2_rcell_reg;
            s3_rlr_reg   <= s2_rlr_reg;
        end
    end

    // ---------------- stage 4: products --------------------------------------
    side_t              s4_side_reg;
    seg_t               s4_seg_reg;
    logic [26:0]        s4_s_reg;
    logic [53:0]        s4_ss_reg;
    logic signed [45:0] s4_xr_reg;
    logic signed [44:0] s4_vm_reg;
    logic [47:0]        s4_dno_reg;
    logic [44:0]        s4_dnt_reg;
    logic [31:0]        s4_rcell_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_side_reg <= '0;
        else if (advance)
            s4_side_reg <= s3_side_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s4_seg_reg   <= s3_seg_reg;
            s4_s_reg     <= s3_s_reg;
            s4_ss_reg    <= 54'(s3_s_reg) * 54'(s3_s_reg);
            s4_xr_reg    <= 46'(s3_x_reg) * 46'($signed({1'b0, ramp_len_reg}));
            s4_vm_reg    <= 45'(s3_side_reg.spd) * 45'($signed({1'b0, s3_m_reg}));
            s4_dno_reg   <= 48'(ramp_len_reg) * 48'(s3_rcell_reg);
            s4_dnt_reg   <= {s3_rlr_reg, 13'b0};
            s4_rcell_reg <= s3_rcell_reg;
        end
    end

    // ---------------- stage 5: numerators and divisors -----------------------
    side_t              s5_side_reg;
    logic signed [63:0] s5_thn_reg;
    logic [DEN_W-1:0]   s5_thd_reg;
    logic signed [63:0] s5_omn_reg;
    logic [DEN_W-1:0]   s5_omd_reg;
    logic signed [63:0] thn;
    logic [DEN_W-1:0]   thd;
    logic signed [63:0] omn;
    logic [DEN_W-1:0]   omd;
    side_t              s5_side_next;

    always_comb
    begin
        thn = '0;
        thd = DEN_W'(1);
        omn = '0;
        omd = DEN_W'(1);
        unique case (s4_seg_reg)
            SEG_ARC:
            begin
                thn = 64'(s4_s_reg);
                thd = DEN_W'(radius_reg);
                omn = 64'(s4_side_reg.spd) <<< 26;
                omd = DEN_W'(s4_rcell_reg);
            end
            SEG_RAMP_IN:
            begin
                thn = 64'(s4_ss_reg);
                thd = DEN_W'(s4_dnt_reg);
                omn = 64'(s4_vm_reg) <<< 14;
                omd = DEN_W'(s4_dno_reg);
            end
            SEG_CONST:
            begin
                thn = 64'({ramp_len_reg, 11'b0}) + 64'(s4_s_reg);
                thd = DEN_W'(radius_reg);
                omn = 64'(s4_side_reg.spd) <<< 26;
                omd = DEN_W'(s4_rcell_reg);
            end
            SEG_RAMP_OUT:
            begin
                thn = (64'(s4_xr_reg) <<< 12) - $signed(64'(s4_ss_reg));
                thd = DEN_W'(s4_dnt_reg);
                omn = 64'(s4_vm_reg) <<< 14;
                omd = DEN_W'(s4_dno_reg);
            end
            default: ;
        endcase
        s5_side_next     = s4_side_reg;
        s5_side_next.fin = (s4_seg_reg == SEG_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_side_reg <= '0;
        else if (advance)
            s5_side_reg <= s5_side_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s5_thn_reg <= thn;
            s5_thd_reg <= thd;
            s5_omn_reg <= omn;
            s5_omd_reg <= omd;
        end
    end

    // ---------------- stage 6: magnitudes ------------------------------------
    side_t            s6_side_reg;
    logic [63:0]      s6_thm_reg;
    logic [DEN_W-1:0] s6_thd_reg;
    logic [63:0]      s6_omm_reg;
    logic [DEN_W-1:0] s6_omd_reg;
    side_t            s6_side_next;

    always_comb
    begin
        s6_side_next        = s5_side_reg;
        s6_side_next.th_neg = s5_thn_reg[63];
        s6_side_next.om_neg = s5_omn_reg[63];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s6_side_reg <= '0;
        else if (advance)
            s6_side_reg <= s6_side_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s6_thm_reg <= s5_thn_reg[63] ? (~s5_thn_reg + 64'd1) : s5_thn_reg;
            s6_thd_reg <= s5_thd_reg;
            s6_omm_reg <= s5_omn_reg[63] ? (~s5_omn_reg + 64'd1) : s5_omn_reg;
            s6_omd_reg <= s5_omd_reg;
        end
    end

    // ---------------- dividers -----------------------------------------------
    logic [QW-1:0] th_q;
    logic          th_ovf;
    logic [QW-1:0] om_q;
    logic          om_ovf;

    stp_div #(.NW(NUM_W), .DW(DEN_W), .QB(QW)) u_div_theta (
        .clk (clk),
        .en  (advance),
        .num (s6_thm_reg),
        .den (s6_thd_reg),
        .quo (th_q),
        .ovf (th_ovf)
    );

    stp_div #(.NW(NUM_W), .DW(DEN_W), .QB(QW)) u_div_omega (
        .clk (clk),
        .en  (advance),
        .num (s6_omm_reg),
        .den (s6_omd_reg),
        .quo (om_q),
        .ovf (om_ovf)
    );

    // Carry control alongside the dividers
    side_t sd_reg [0:DIV_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIV_LAT; k++)
                sd_reg[k] <= '0;
        end
        else if (advance)
        begin
            sd_reg[0] <= s6_side_reg;
            for (int k = 1; k < DIV_LAT; k++)
                sd_reg[k] <= sd_reg[k-1];
        end
    end

    // ---------------- output: sign, saturate, hold ---------------------------
    side_t              so;
    logic               tneg;
    logic               oneg;
    logic               th_sat;
    logic               om_sat;
    logic signed [15:0] head_next;
    logic signed [23:0] rate_next;

    assign so   = sd_reg[DIV_LAT-1];
    assign tneg = so.th_neg ^ so.neg;
    assign oneg = so.om_neg ^ so.neg;
    assign th_sat = th_ovf || (th_q > (QW'(32767) + QW'(tneg)));
    assign om_sat = om_ovf || (om_q > (QW'(8388607) + QW'(oneg)));

    always_comb
    begin
        priority if (so.bad)
        begin
            head_next = '0;
            rate_next = '0;
        end
        else if (so.fin)
        begin
            head_next = angle_reg;
            rate_next = '0;
        end
        else
        begin
            if (th_sat)
                head_next = tneg ? 16'sh8000 : 16'sh7FFF;
            else
                head_next = $signed(16'(tneg ? (~th_q + QW'(1)) : th_q));
            if (om_sat)
                rate_next = oneg ? 24'sh800000 : 24'sh7FFFFF;
            else
                rate_next = $signed(24'(oneg ? (~om_q + QW'(1)) : om_q));
        end
    end

    logic               out_vld_reg;
    logic signed [15:0] head_reg;
    logic signed [23:0] rate_reg;
    logic signed [15:0] spd_reg;
    logic               vres_reg;

    assign advance = !out_vld_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= so.vld;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            head_reg <= head_next;
            rate_reg <= rate_next;
            spd_reg  <= so.spd;
            vres_reg <= !so.bad;
        end
    end

    assign sample.ready        = advance;
    assign result.valid        = out_vld_reg;
    assign result.heading      = head_reg;
    assign result.angular_rate = rate_reg;
    assign result.speed_out    = spd_reg;
    assign result.valid_res    = vres_reg;

endmodule

@@ src/stp_div.sv @@
module stp_div
    import stp_pkg::*;
#(
    parameter int NW = 64,
    parameter int DW = 49,
    parameter int QB = 25
)
(
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QB-1:0] quo,
    output logic          ovf
);

    localparam int W = ((NW + 1) > (DW + QB)) ? (NW + 1) : (DW + QB);

    logic [NW:0]   n_reg;
    logic [DW-1:0] da_reg;
    logic [W-1:0]  r_reg [0:QB];
    logic [DW-1:0] d_reg [0:QB];
    logic [QB-1:0] q_reg [0:QB];
    logic          o_reg [0:QB];

    // Add half the divisor for round to nearest
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg  <= {1'b0, num} + (NW + 1)'(den >> 1);
            da_reg <= den;
        end
    end

    // Flag quotients that do not fit in QB bits
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0] <= W'(n_reg);
            d_reg[0] <= da_reg;
            q_reg[0] <= '0;
            o_reg[0] <= (W'(n_reg) >= (W'(da_reg) << QB));
        end
    end

    // One restoring step per stage, most significant bit first
    for (genvar k = 1; k <= QB; k++)
    begin : g_step
        logic [W-1:0] dsh;
        assign dsh = W'(d_reg[k-1]) << (QB - k);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[k] <= d_reg[k-1];
                o_reg[k] <= o_reg[k-1];
                if (r_reg[k-1] >= dsh)
                begin
                    r_reg[k] <= r_reg[k-1] - dsh;
                    q_reg[k] <= q_reg[k-1] | (QB'(1) << (QB - k));
                end
                else
                begin
                    r_reg[k] <= r_reg[k-1];
                    q_reg[k] <= q_reg[k-1];
                end
            end
        end
    end

    assign quo = q_reg[QB];
    assign ovf = o_reg[QB];

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import stp_pkg::*;

    // Idle clocks after the last result before the next register write
    localparam int DRAIN_CYCLES = 45;
    localparam int RANDOM_PHASES = 14;
    localparam int ITEMS_PER_PHASE = 100;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    bit          ready_busy;
    int          sent_items;
    int          phase_count;

    stp_in_if  sample ();
    stp_out_if result ();

    smooth_turn_heading_profile dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample),
        .result    (result)
    );

    typedef struct {
        logic signed [15:0] heading;
        logic signed [23:0] angular_rate;
        logic signed [15:0] speed_out;
        logic               valid_res;
    } heading_result_t;

    class heading_scoreboard;
        heading_result_t    pending[$];
        int                 errors;
        int                 checked;
        logic [15:0]        radius;
        logic signed [15:0] angle;
        logic [15:0]        ramp_len;
        logic [15:0]        lead_in;
        logic [15:0]        lead_out;
        logic [15:0]        cell_m;

        function new();
            errors = 0;
            checked = 0;
            radius = 16'd512;
            angle = 16'sd6434;
            ramp_len = 16'd0;
            lead_in = 16'd0;
            lead_out = 16'd0;
            cell_m = 16'd11796;
        endfunction

        function void set_reg(reg_idx_t idx, logic [15:0] value);
            case (idx)
                REG_TURN_RADIUS:     radius = value;
                REG_TURN_ANGLE:      angle = value;
                REG_RAMP_LENGTH:     ramp_len = value;
                REG_LEAD_IN_LENGTH:  lead_in = value;
                REG_LEAD_OUT_LENGTH: lead_out = value;
                REG_CELL_METERS:     cell_m = value;
                default: ;
            endcase
        endfunction

        // Profile length in whole cells (Q0), used to aim the travelled distance
        function longint total_cells();
            longint a;
            a = (angle < 0) ? -longint'(angle) : longint'(angle);
            return longint'(lead_in) + longint'(ramp_len) + longint'(lead_out)
                + ((a * longint'(radius)) >>> 12);
        endfunction

        // Round to nearest on the magnitude, ties away from zero
        function longint round_div(longint num, longint den);
            longint mag;
            longint q;
            if (den == 0)
                return 0;
            mag = (num < 0) ? -num : num;
            q = (mag + den / 2) / den;
            return (num < 0) ? -q : q;
        endfunction

        function longint clip(longint v, int w);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (w - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) return hi;
            if (v < lo) return lo;
            return v;
        endfunction

        // Work out heading and rate for an accepted request
        function void note_request(logic signed [15:0] trav, logic signed [15:0] spd);
            heading_result_t e;
            longint ang, r, rl, arc, ramp, pre, post, cnst, total, d;
            longint rin, cend, rout, s, num, theta, omega, head, rcell, v;
            bit fin;
            ang = longint'(angle);
            r = longint'(radius);
            rl = longint'(ramp_len);
            v = longint'(spd);
            rcell = r * longint'(cell_m);
            theta = 0;
            omega = 0;
            fin = 0;
            e.speed_out = spd;
            if (radius == 0 || cell_m == 0 || angle == 0) begin
                e.heading = '0;
                e.angular_rate = '0;
                e.valid_res = 1'b0;
                pending.push_back(e);
                return;
            end
            arc = ((ang < 0) ? -ang : ang) * r;
            ramp = rl <<< 12;
            pre = longint'(lead_in) <<< 12;
            post = longint'(lead_out) <<< 12;
            cnst = arc - ramp;
            total = pre + ramp + arc + post;
            d = (trav < 0) ? 0 : (longint'(trav) <<< 12);
            if (d > total) d = total;
            rin = pre + ramp;
            cend = rin + cnst;
            rout = cend + ramp;
            if (d <= pre) begin
                // lead-in: nothing turns yet
            end else if (rl == 0) begin
                if (d <= cend) begin
                    theta = round_div(d - pre, r);
                    omega = round_div(v * (longint'(1) <<< 26), rcell);
                end else begin
                    fin = 1;
                end
            end else if (d <= rin) begin
                s = d - pre;
                theta = round_div(s * s, 2 * rl * 4096 * r);
                omega = round_div(v * s * 16384, rl * rcell);
            end else if (d <= cend) begin
                s = d - rin;
                theta = round_div(rl * 2048 + s, r);
                omega = round_div(v * (longint'(1) <<< 26), rcell);
            end else if (d <= rout) begin
                s = d - cend;
                num = (2 * arc - ramp + 2 * s) * ramp - s * s;
                theta = round_div(num, 2 * ramp * r);
                omega = round_div(v * (ramp - s) * 16384, rl * rcell);
            end else begin
                fin = 1;
            end
            if (fin) begin
                head = ang;
                omega = 0;
            end else begin
                head = (ang < 0) ? -theta : theta;
                if (ang < 0) omega = -omega;
            end
            e.heading = clip(head, 16);
            e.angular_rate = clip(omega, 24);
            e.valid_res = 1'b1;
            pending.push_back(e);
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH at %0t: %s", $time, msg);
        endtask

        // Compare one result with the oldest expectation
        task check_result(heading_result_t got);
            heading_result_t e;
            if (pending.size() == 0) begin
                report("result arrived with nothing expected");
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got.heading !== e.heading)
                report($sformatf("heading %0d, expected %0d", got.heading, e.heading));
            if (got.angular_rate !== e.angular_rate)
                report($sformatf("angular_rate %0d, expected %0d",
                    got.angular_rate, e.angular_rate));
            if (got.speed_out !== e.speed_out)
                report($sformatf("speed_out %0d, expected %0d", got.speed_out, e.speed_out));
            if (got.valid_res !== e.valid_res)
                report($sformatf("valid_res %0b, expected %0b", got.valid_res, e.valid_res));
        endtask
    endclass

    heading_scoreboard profile_sb = new();

    // Clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Stall the result side at random
    always @(negedge clk)
    begin
        int stall;
        if (!rst_n || ready_busy) begin
            result.ready <= 1'b1;
        end else begin
            stall = pick_gap();
            if (stall > 0) begin
                result.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result.ready <= 1'b1;
        end
    end

    // Collect results at the rising edge
    always @(posedge clk)
    begin
        heading_result_t got;
        if (rst_n && result.valid && result.ready) begin
            got.heading = result.heading;
            got.angular_rate = result.angular_rate;
            got.speed_out = result.speed_out;
            got.valid_res = result.valid_res;
            profile_sb.check_result(got);
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [15:0] value);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        profile_sb.set_reg(idx, value);
    endtask

    task automatic load_profile(logic [15:0] radius, logic [15:0] angle, logic [15:0] ramp,
                                logic [15:0] lin, logic [15:0] lout, logic [15:0] cell_size);
        write_reg(REG_TURN_RADIUS, radius);
        write_reg(REG_TURN_ANGLE, angle);
        write_reg(REG_RAMP_LENGTH, ramp);
        write_reg(REG_LEAD_IN_LENGTH, lin);
        write_reg(REG_LEAD_OUT_LENGTH, lout);
        write_reg(REG_CELL_METERS, cell_size);
        phase_count++;
    endtask

    // Present one request and hold it until accepted
    task automatic send_request(logic [15:0] trav, logic [15:0] spd, bit busy);
        int gap;
        @(negedge clk);
        gap = busy ? 0 : pick_gap();
        if (gap > 0) begin
            sample.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample.valid = 1'b1;
        sample.travelled = trav;
        sample.forward_speed = spd;
        do
            @(posedge clk);
        while (!sample.ready);
        profile_sb.note_request(trav, spd);
        sent_items++;
    endtask

    // Wait for all results, then let the pipeline settle before a write
    task automatic drain();
        @(negedge clk);
        sample.valid = 1'b0;
        while (profile_sb.pending.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Hit the segment boundaries and the input extremes
    task automatic directed_points();
        longint lin, rl, tot;
        lin = profile_sb.lead_in;
        rl = profile_sb.ramp_len;
        tot = profile_sb.total_cells();
        send_request(16'h8000, 16'h7FFF, 1'b0);
        send_request(16'h0000, 16'h8000, 1'b0);
        send_request(16'h7FFF, 16'h1000, 1'b0);
        send_request(16'(lin), 16'hF000, 1'b0);
        send_request(16'(lin + 1), 16'h7FFF, 1'b0);
        send_request(16'(lin + rl), 16'h8000, 1'b0);
        send_request(16'(lin + rl + 1), 16'h0800, 1'b0);
        send_request(16'(tot - lin - rl), 16'h7FFF, 1'b0);
        send_request(16'(tot - profile_sb.lead_out), 16'h8000, 1'b0);
        send_request(16'(tot), 16'h0000, 1'b0);
        send_request(16'(tot / 2), 16'hFFFF, 1'b0);
        drain();
    endtask

    task automatic random_profile();
        logic [15:0] radius, angle, ramp, lin, lout, cell_size;
        int r;
        r = $urandom_range(0, 19);
        radius = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom_range(64, 4096));
        r = $urandom_range(0, 19);
        angle = (r == 0) ? 16'd0 : (r == 1) ? 16'h8000 : (r == 2) ? 16'h7FFF
            : 16'($urandom_range(0, 25736) - 12868);
        ramp = ($urandom_range(0, 2) == 0) ? 16'd0
            : ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(1, 4096));
        lin = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 4096));
        lout = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 4096));
        r = $urandom_range(0, 19);
        cell_size = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom_range(1, 65535));
        load_profile(radius, angle, ramp, lin, lout, cell_size);
    endtask

    // Aim most distances inside the profile, some anywhere
    task automatic random_requests(int count);
        longint hi;
        logic [15:0] trav;
        bit busy;
        busy = ($urandom_range(0, 3) == 0);
        ready_busy = busy;
        hi = profile_sb.total_cells() + 200;
        if (hi > 32767) hi = 32767;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 4) == 0)
                trav = 16'($urandom());
            else
                trav = 16'(longint'($urandom_range(0, 32'(hi + 200))) - 200);
            send_request(trav, 16'($urandom()), busy);
        end
        drain();
        ready_busy = 1'b0;
    endtask

    // Main sequence
    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sample.valid = 1'b0;
        sample.travelled = '0;
        sample.forward_speed = '0;
        result.ready = 1'b0;
        ready_busy = 1'b0;
        sent_items = 0;
        phase_count = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        directed_points();
        load_profile(16'd1024, 16'd6434, 16'd512, 16'd300, 16'd200, 16'd11796);
        directed_points();
        load_profile(16'd1024, 16'hE6DE, 16'd4000, 16'd0, 16'd0, 16'hFFFF);
        directed_points();
        load_profile(16'hFFFF, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1);
        directed_points();
        load_profile(16'd0, 16'd6434, 16'd0, 16'd0, 16'd0, 16'd11796);
        send_request(16'd100, 16'h7FFF, 1'b0);
        drain();
        load_profile(16'd512, 16'd0, 16'd0, 16'd0, 16'd0, 16'd11796);
        send_request(16'd100, 16'h8000, 1'b0);
        drain();
        load_profile(16'd512, 16'd6434, 16'd0, 16'd0, 16'd0, 16'd0);
        send_request(16'd100, 16'h1234, 1'b0);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            random_profile();
            random_requests(ITEMS_PER_PHASE);
        end

        $display("Sent %0d requests over %0d register settings, %0d results checked",
            sent_items, phase_count, profile_sb.checked);
        $display("Covered lead-in, ramps, arc, lead-out, clamping and invalid settings");
        if (profile_sb.errors == 0 && profile_sb.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Hard stop if the handshakes hang
    initial
    begin
        #5ms;
        $display("Timeout waiting on the block");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
